@@ rtl/core/assert_macros.svh @@
// Assertion helpers shared by the RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, off while in reset
`define AST_IMPLY(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// next-cycle implication, off while in reset
`define AST_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

@@ rtl/core/pas_pkg.sv @@
// ----------------------------------------------------------------------------
// pas_pkg
// Types, codes and helpers of the process address-space table.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package pas_pkg;

	localparam int ENTRIES_DEF    = 128;
	localparam int NAME_CHARS_DEF = 15;
	localparam int NAME_MAX       = 15;

	localparam logic [7:0] CHAR_LO  = 8'h20;
	localparam logic [7:0] CHAR_HI  = 8'h7F;
	localparam logic [7:0] CHAR_SUB = 8'h3F;
	localparam logic [7:0] CASE_OFS = 8'd32;
	localparam logic [7:0] UPPER_A  = 8'h41;
	localparam logic [7:0] UPPER_Z  = 8'h5A;

	typedef enum logic [2:0] {
		ACT_CREATE    = 3'd0,
		ACT_TERMINATE = 3'd1,
		ACT_FIND_ID   = 3'd2,
		ACT_FIND_NAME = 3'd3,
		ACT_FIND_BASE = 3'd4
	} action_t;

	typedef enum logic [2:0] {
		ST_OK        = 3'd0,
		ST_NOT_FOUND = 3'd1,
		ST_FULL      = 3'd2,
		ST_DUP_ID    = 3'd3,
		ST_BAD_NAME  = 3'd4
	} status_t;

	typedef enum logic [1:0] {
		FSM_IDLE,
		FSM_SCAN,
		FSM_DECIDE,
		FSM_RENUM
	} fsm_t;

	typedef struct packed {
		logic [2:0]  action;
		logic [31:0] proc_id;
		logic [63:0] base_value;
		logic [63:0] name_low;
		logic [55:0] name_high;
		logic [4:0]  name_len;
	} cmd_t;

	typedef struct packed {
		logic [2:0]  status;
		logic [31:0] pid_out;
		logic [63:0] base_out;
		logic [63:0] name_low_out;
		logic [55:0] name_high_out;
		logic [7:0]  live_count;
	} result_t;

	typedef struct packed {
		logic [31:0] id;
		logic [63:0] base;
		logic [55:0] name_high;
		logic [63:0] name_low;
	} entry_t;

	typedef struct packed {
		logic id_eq;
		logic base_eq;
		logic name_eq;
	} match_t;

	function automatic logic [7:0] fold(input logic [7:0] c);
		logic [7:0] r;
		r = c;
		if (c >= UPPER_A && c <= UPPER_Z) begin
			r = c + CASE_OFS;
		end
		return r;
	endfunction

	// truncate to nchars, replace non-printable bytes, zero the tail
	function automatic logic [119:0] sanitize(input logic [119:0] name,
			input logic [4:0] len, input int nchars);
		logic [119:0] r;
		logic [7:0]   b;
		r = '0;
		for (int k = 0; k < NAME_MAX; k++) begin
			b = name[8*k +: 8];
			if (k < int'(len) && k < nchars) begin
				if (b < CHAR_LO || b >= CHAR_HI) begin
					b = CHAR_SUB;
				end
				r[8*k +: 8] = b;
			end
		end
		return r;
	endfunction

endpackage

`default_nettype wire

@@ rtl/core/pas_ram.sv @@
// ----------------------------------------------------------------------------
// pas_ram
// Generic RAM, one write port and one registered read port.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pas_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire                      clk,
	input  wire                      we,
	input  wire [$clog2(DEPTH)-1:0]  waddr,
	input  wire [WIDTH-1:0]          wdata,
	input  wire [$clog2(DEPTH)-1:0]  raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

@@ rtl/core/pas_match.sv @@
// ----------------------------------------------------------------------------
// pas_match
// Shared compare unit: one stored entry against the current command.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pas_match (
	input  pas_pkg::entry_t entry,
	input  pas_pkg::cmd_t   cmd,
	output pas_pkg::match_t match
);

	logic [119:0] qname;
	logic [119:0] sname;
	logic         same;

	always_comb begin
		qname = {cmd.name_high, cmd.name_low};
		sname = {entry.name_high, entry.name_low};
		same  = 1'b1;
		for (int k = 0; k < pas_pkg::NAME_MAX; k++) begin
			// query bytes past the length count as zero
			if (pas_pkg::fold((k < int'(cmd.name_len)) ? qname[8*k +: 8] : 8'h00)
					!= pas_pkg::fold(sname[8*k +: 8])) begin
				same = 1'b0;
			end
		end
		match.id_eq   = (entry.id == cmd.proc_id);
		match.base_eq = (entry.base == cmd.base_value);
		match.name_eq = same;
	end

endmodule

`default_nettype wire

@@ rtl/core/process_address_space_table_unit.sv @@
// ----------------------------------------------------------------------------
// process_address_space_table_unit
// Table of live processes with create, terminate and three lookups.
// ----------------------------------------------------------------------------
// Usage: drive cmd and raise start; the command transfers at a clock edge
// where start is high and busy is low. busy stays high until the result is
// out. The result appears on result for one cycle with done high and must be
// taken then; there is no back-pressure.
// Scan: every command scans all entries through the one entry RAM read port
// and the shared compare unit before done. A terminate that removes an entry
// adds a second pass over the RAM to renumber age ranks. A new command may
// transfer in the cycle done is high.
// Reset: all entries invalid, live count zero. No clearing pass is needed,
// per-entry valid flops gate the RAM contents.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module process_address_space_table_unit #(
	parameter int ENTRIES    = pas_pkg::ENTRIES_DEF,
	parameter int NAME_CHARS = pas_pkg::NAME_CHARS_DEF
) (
	input  wire               clk,
	input  wire               arst_n,
	input  wire               start,
	output logic              busy,
	input  pas_pkg::cmd_t     cmd,
	output logic              done,
	output pas_pkg::result_t  result
);

	localparam int IW    = $clog2(ENTRIES);
	localparam int CW    = $clog2(ENTRIES + 1);
	localparam int EW    = $bits(pas_pkg::entry_t);
	localparam int RAM_W = EW + IW;

	pas_pkg::fsm_t    state_q, state_d;
	pas_pkg::cmd_t    cmd_q;
	pas_pkg::result_t res_q, res_d;
	pas_pkg::entry_t  rd_entry, hit_rec_q, new_rec;
	pas_pkg::match_t  mt;

	logic [ENTRIES-1:0] valid_q;
	logic [CW-1:0]      count_q, count_d;
	logic [IW-1:0]      rd_idx_q, chk_idx_s1, free_q, hit_idx_q, best_rank_q;
	logic               issue_q, chk_vld_s1, free_found_q, hit_q, done_d;
	logic [IW-1:0]      rd_rank;
	logic [RAM_W-1:0]   ram_rdata, ram_wdata;
	logic [IW-1:0]      ram_waddr;
	logic               ram_we;
	logic               kick, chk_last, entry_live, cand;
	logic               vld_set, vld_clr;
	logic [119:0]       clean_name;

	pas_ram #(.WIDTH(RAM_W), .DEPTH(ENTRIES)) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (rd_idx_q),
		.rdata (ram_rdata)
	);

	assign rd_entry = pas_pkg::entry_t'(ram_rdata[RAM_W-1:IW]);
	assign rd_rank  = ram_rdata[IW-1:0];

	pas_match u_match (
		.entry (rd_entry),
		.cmd   (cmd_q),
		.match (mt)
	);

	assign chk_last   = chk_vld_s1 && (chk_idx_s1 == IW'(ENTRIES - 1));
	assign entry_live = valid_q[chk_idx_s1];

	always_comb begin
		unique case (pas_pkg::action_t'(cmd_q.action))
			pas_pkg::ACT_CREATE, pas_pkg::ACT_TERMINATE,
			pas_pkg::ACT_FIND_ID:   cand = mt.id_eq;
			pas_pkg::ACT_FIND_NAME: cand = mt.name_eq;
			pas_pkg::ACT_FIND_BASE: cand = mt.base_eq;
			default:                cand = 1'b0;
		endcase
	end

	assign clean_name = pas_pkg::sanitize({cmd_q.name_high, cmd_q.name_low},
		cmd_q.name_len, NAME_CHARS);

	always_comb begin
		new_rec.id        = cmd_q.proc_id;
		new_rec.base      = cmd_q.base_value;
		new_rec.name_high = clean_name[119:64];
		new_rec.name_low  = clean_name[63:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= pas_pkg::FSM_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		ram_we    = 1'b0;
		ram_waddr = chk_idx_s1;
		ram_wdata = {rd_entry, rd_rank - IW'(1)};
		res_d     = res_q;
		count_d   = count_q;
		vld_set   = 1'b0;
		vld_clr   = 1'b0;
		kick      = 1'b0;
		done_d    = 1'b0;
		unique case (state_q)
			pas_pkg::FSM_IDLE: begin
				if (start) begin
					kick    = 1'b1;
					state_d = pas_pkg::FSM_SCAN;
				end
			end
			pas_pkg::FSM_SCAN: begin
				if (chk_last) begin
					state_d = pas_pkg::FSM_DECIDE;
				end
			end
			pas_pkg::FSM_DECIDE: begin
				res_d        = '0;
				res_d.status = pas_pkg::ST_NOT_FOUND;
				state_d      = pas_pkg::FSM_IDLE;
				done_d       = 1'b1;
				unique case (pas_pkg::action_t'(cmd_q.action))
					pas_pkg::ACT_CREATE: begin
						if (hit_q) begin
							res_d.status = pas_pkg::ST_DUP_ID;
						end else if (count_q >= CW'(ENTRIES)) begin
							res_d.status = pas_pkg::ST_FULL;
						end else begin
							ram_we              = 1'b1;
							ram_waddr           = free_q;
							ram_wdata           = {new_rec, IW'(count_q)};
							vld_set             = 1'b1;
							count_d             = count_q + CW'(1);
							res_d.status        = pas_pkg::ST_OK;
							res_d.pid_out       = new_rec.id;
							res_d.base_out      = new_rec.base;
							res_d.name_low_out  = new_rec.name_low;
							res_d.name_high_out = new_rec.name_high;
						end
					end
					pas_pkg::ACT_TERMINATE: begin
						if (hit_q) begin
							vld_clr             = 1'b1;
							count_d             = count_q - CW'(1);
							kick                = 1'b1;
							done_d              = 1'b0;
							state_d             = pas_pkg::FSM_RENUM;
							res_d.status        = pas_pkg::ST_OK;
							res_d.pid_out       = hit_rec_q.id;
							res_d.name_low_out  = hit_rec_q.name_low;
							res_d.name_high_out = hit_rec_q.name_high;
						end
					end
					pas_pkg::ACT_FIND_ID, pas_pkg::ACT_FIND_NAME,
					pas_pkg::ACT_FIND_BASE: begin
						if (cmd_q.action == pas_pkg::ACT_FIND_NAME &&
								(cmd_q.name_len == 5'd0 ||
								 int'(cmd_q.name_len) > NAME_CHARS)) begin
							res_d.status = pas_pkg::ST_BAD_NAME;
						end else if (hit_q) begin
							res_d.status        = pas_pkg::ST_OK;
							res_d.pid_out       = hit_rec_q.id;
							res_d.base_out      = hit_rec_q.base;
							res_d.name_low_out  = hit_rec_q.name_low;
							res_d.name_high_out = hit_rec_q.name_high;
						end
					end
					default: ;
				endcase
				res_d.live_count = 8'(count_d);
			end
			pas_pkg::FSM_RENUM: begin
				// drop the rank of every entry younger than the removed one
				if (chk_vld_s1 && entry_live && rd_rank > best_rank_q) begin
					ram_we = 1'b1;
				end
				if (chk_last) begin
					done_d  = 1'b1;
					state_d = pas_pkg::FSM_IDLE;
				end
			end
			default: state_d = pas_pkg::FSM_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q      <= '0;
			count_q      <= '0;
			issue_q      <= 1'b0;
			chk_vld_s1   <= 1'b0;
			hit_q        <= 1'b0;
			free_found_q <= 1'b0;
			done         <= 1'b0;
			rd_idx_q     <= '0;
		end else begin
			done    <= done_d;
			count_q <= count_d;
			if (vld_set) begin
				valid_q[free_q] <= 1'b1;
			end
			if (vld_clr) begin
				valid_q[hit_idx_q] <= 1'b0;
			end
			chk_vld_s1 <= issue_q;
			if (kick) begin
				rd_idx_q <= '0;
				issue_q  <= 1'b1;
			end else if (issue_q) begin
				if (rd_idx_q == IW'(ENTRIES - 1)) begin
					issue_q <= 1'b0;
				end else begin
					rd_idx_q <= rd_idx_q + IW'(1);
				end
			end
			if (kick && state_q == pas_pkg::FSM_IDLE) begin
				hit_q        <= 1'b0;
				free_found_q <= 1'b0;
			end else if (state_q == pas_pkg::FSM_SCAN && chk_vld_s1) begin
				if (!entry_live && !free_found_q) begin
					free_found_q <= 1'b1;
				end
				// keep the newest match
				if (entry_live && cand && (!hit_q || rd_rank > best_rank_q)) begin
					hit_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		chk_idx_s1 <= rd_idx_q;
		res_q      <= res_d;
		if (state_q == pas_pkg::FSM_IDLE && start) begin
			cmd_q <= cmd;
		end
		if (state_q == pas_pkg::FSM_SCAN && chk_vld_s1) begin
			if (!entry_live && !free_found_q) begin
				free_q <= chk_idx_s1;
			end
			if (entry_live && cand && (!hit_q || rd_rank > best_rank_q)) begin
				hit_idx_q   <= chk_idx_s1;
				best_rank_q <= rd_rank;
				hit_rec_q   <= rd_entry;
			end
		end
	end

	assign busy   = (state_q != pas_pkg::FSM_IDLE);
	assign result = res_q;

	`AST_NEXT(a_done_pulse, clk, arst_n, done, !done)
	`AST_IMPLY(a_count_bound, clk, arst_n, 1'b1, count_q <= CW'(ENTRIES))
	`AST_IMPLY(a_write_phase, clk, arst_n, ram_we, state_q == pas_pkg::FSM_DECIDE || state_q == pas_pkg::FSM_RENUM)
	`AST_NEXT(a_start_busy, clk, arst_n, start && !busy, busy)

endmodule

`default_nettype wire

@@ tb/sv/process_address_space_table_unit_tb.sv @@
// ----------------------------------------------------------------------------
// process_address_space_table_unit_tb
// Drives create, terminate and lookup commands into the process table and
// checks each result against a software copy of the table kept in the bench.
// The table is filled past full, emptied, and probed by id, name and base.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module process_address_space_table_unit_tb;
	import pas_pkg::*;

	localparam int SLOTS    = 128;
	localparam int NCHARS   = 15;
	localparam int WATCHDOG = 5000;
	localparam int DRAIN    = 300;
	localparam int RAND_CMDS = 1130;

	typedef struct {
		cmd_t c;
		int   idle_pct;
	} pending_t;

	logic    clk = 1'b0;
	logic    arst_n = 1'b0;
	logic    start = 1'b0;
	cmd_t    cmd = '0;
	logic    busy;
	logic    done;
	result_t result;

	pending_t pending_q[$];
	result_t  result_q[$];
	int       error_count = 0;
	int       stall_cycles = 0;
	int       idle_pct = 0;

	// shadow of the process table
	bit           tbl_valid[SLOTS];
	logic [31:0]  tbl_id[SLOTS];
	logic [63:0]  tbl_base[SLOTS];
	logic [119:0] tbl_name[SLOTS];
	int           tbl_rank[SLOTS];
	int           tbl_count = 0;

	// names, ids and bases handed out so far, for lookups that can hit
	logic [119:0] used_names[$];
	logic [4:0]   used_lens[$];
	logic [31:0]  used_pids[$];
	logic [63:0]  used_bases[$];

	process_address_space_table_unit dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.cmd(cmd),
		.done(done),
		.result(result)
	);

	always #10 clk = ~clk;

	function automatic logic [7:0] lower(input logic [7:0] c);
		return (c >= UPPER_A && c <= UPPER_Z) ? c + CASE_OFS : c;
	endfunction

	function automatic int find_pid(input logic [31:0] pid);
		for (int i = 0; i < SLOTS; i++) begin
			if (tbl_valid[i] && tbl_id[i] == pid) begin
				return i;
			end
		end
		return -1;
	endfunction

	function automatic result_t table_step(input cmd_t c);
		result_t      r;
		int           hit;
		int           slot;
		int           len;
		bit           term;
		bit           same;
		logic [119:0] nm;
		logic [119:0] w;
		logic [7:0]   b;
		r = '0;
		r.status = ST_NOT_FOUND;
		hit = -1;
		term = 1'b0;
		nm = {c.name_high, c.name_low};
		case (c.action)
			ACT_CREATE: begin
				if (find_pid(c.proc_id) >= 0) begin
					r.status = ST_DUP_ID;
				end else if (tbl_count >= SLOTS) begin
					r.status = ST_FULL;
				end else begin
					slot = 0;
					while (tbl_valid[slot]) slot++;
					len = (c.name_len > NCHARS) ? NCHARS : int'(c.name_len);
					w = '0;
					for (int k = 0; k < len; k++) begin
						b = nm[8*k +: 8];
						if (b < CHAR_LO || b >= CHAR_HI) begin
							b = CHAR_SUB;
						end
						w[8*k +: 8] = b;
					end
					tbl_valid[slot] = 1'b1;
					tbl_id[slot] = c.proc_id;
					tbl_base[slot] = c.base_value;
					tbl_name[slot] = w;
					tbl_rank[slot] = tbl_count;
					tbl_count++;
					hit = slot;
					r.status = ST_OK;
				end
			end
			ACT_TERMINATE: begin
				hit = find_pid(c.proc_id);
				if (hit >= 0) begin
					tbl_valid[hit] = 1'b0;
					// younger entries move up one rank
					for (int i = 0; i < SLOTS; i++) begin
						if (tbl_valid[i] && tbl_rank[i] > tbl_rank[hit]) begin
							tbl_rank[i]--;
						end
					end
					tbl_count--;
					term = 1'b1;
					r.status = ST_OK;
				end
			end
			ACT_FIND_ID: begin
				hit = find_pid(c.proc_id);
				if (hit >= 0) r.status = ST_OK;
			end
			ACT_FIND_NAME: begin
				if (c.name_len == 0 || c.name_len > NCHARS) begin
					r.status = ST_BAD_NAME;
				end else begin
					w = '0;
					for (int k = 0; k < int'(c.name_len); k++) begin
						w[8*k +: 8] = nm[8*k +: 8];
					end
					for (int i = 0; i < SLOTS; i++) begin
						if (tbl_valid[i]) begin
							same = 1'b1;
							for (int k = 0; k < NCHARS; k++) begin
								if (lower(w[8*k +: 8]) != lower(tbl_name[i][8*k +: 8])) begin
									same = 1'b0;
								end
							end
							if (same && (hit < 0 || tbl_rank[i] > tbl_rank[hit])) begin
								hit = i;
							end
						end
					end
					if (hit >= 0) r.status = ST_OK;
				end
			end
			ACT_FIND_BASE: begin
				for (int i = 0; i < SLOTS; i++) begin
					if (tbl_valid[i] && tbl_base[i] == c.base_value &&
							(hit < 0 || tbl_rank[i] > tbl_rank[hit])) begin
						hit = i;
					end
				end
				if (hit >= 0) r.status = ST_OK;
			end
			default: ;
		endcase
		if (r.status == ST_OK) begin
			r.pid_out = tbl_id[hit];
			r.base_out = term ? 64'd0 : tbl_base[hit];
			r.name_low_out = tbl_name[hit][63:0];
			r.name_high_out = tbl_name[hit][119:64];
		end
		r.live_count = tbl_count[7:0];
		return r;
	endfunction

	task automatic report_mismatch(input string msg);
		$display("MISMATCH at %0t: %s", $time, msg);
		error_count++;
	endtask

	task automatic check_field(input string fname, input logic [63:0] got,
			input logic [63:0] want);
		if (got !== want) begin
			report_mismatch($sformatf("%s got %0h want %0h", fname, got, want));
		end
	endtask

	task automatic push_cmd(input action_t act, input logic [31:0] pid,
			input logic [63:0] base, input logic [119:0] nm, input logic [4:0] len);
		pending_t p;
		p.c.action = act;
		p.c.proc_id = pid;
		p.c.base_value = base;
		p.c.name_low = nm[63:0];
		p.c.name_high = nm[119:64];
		p.c.name_len = len;
		p.idle_pct = idle_pct;
		pending_q.push_back(p);
		if (act == ACT_CREATE) begin
			used_names.push_back(nm);
			used_lens.push_back(len);
			used_pids.push_back(pid);
			used_bases.push_back(base);
		end
	endtask

	function automatic logic [119:0] random_name();
		logic [119:0] nm;
		int           pick;
		for (int k = 0; k < NCHARS; k++) begin
			pick = $urandom_range(0, 9);
			if (pick < 6) nm[8*k +: 8] = 8'h61 + 8'($urandom_range(0, 3));
			else if (pick < 8) nm[8*k +: 8] = UPPER_A + 8'($urandom_range(0, 3));
			else nm[8*k +: 8] = 8'($urandom);
		end
		return nm;
	endfunction

	function automatic logic [63:0] random_base();
		if ($urandom_range(0, 1)) return 64'($urandom_range(0, 15)) << 12;
		return {$urandom, $urandom};
	endfunction

	// transfer a command whenever start is high and busy is low
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start <= 1'b0;
		end else begin
			if (start && !busy) begin
				result_q.push_back(table_step(cmd));
			end
			if (!start || !busy) begin
				if (pending_q.size() > 0 &&
						$urandom_range(0, 99) >= pending_q[0].idle_pct) begin
					cmd <= pending_q[0].c;
					void'(pending_q.pop_front());
					start <= 1'b1;
				end else begin
					start <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && done) begin
			if (result_q.size() == 0) begin
				report_mismatch("result with nothing outstanding");
			end else begin
				result_t want;
				want = result_q.pop_front();
				check_field("status", result.status, want.status);
				check_field("pid_out", result.pid_out, want.pid_out);
				check_field("base_out", result.base_out, want.base_out);
				check_field("name_low_out", result.name_low_out, want.name_low_out);
				check_field("name_high_out", result.name_high_out, want.name_high_out);
				check_field("live_count", result.live_count, want.live_count);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((start && !busy) || done) begin
				stall_cycles <= 0;
			end else begin
				stall_cycles <= stall_cycles + 1;
			end
			if (stall_cycles >= WATCHDOG) begin
				$display("DONE: errors detected");
				$finish;
			end
		end
	end

	initial begin
		logic [119:0] nm;
		logic [4:0]   len;
		int           pick;
		int           idx;
		bit           grow;

		idle_pct = 38;
		// directed: field extremes and each corner case
		push_cmd(ACT_CREATE, 32'd0, 64'd0, '0, 5'd0);
		nm = {8'hFF, "z~ INIT.Proc9", 8'h1F};
		push_cmd(ACT_CREATE, 32'hFFFF_FFFF, '1, nm, 5'd16);
		push_cmd(ACT_CREATE, 32'd0, 64'd5, "x", 5'd1);
		push_cmd(ACT_CREATE, 32'd5, '1, "Shell", 5'd5);
		push_cmd(ACT_CREATE, 32'd6, 64'd7, "shell", 5'd5);
		push_cmd(ACT_FIND_ID, 32'd0, '0, '0, 5'd0);
		push_cmd(ACT_FIND_ID, 32'hFFFF_FFFF, '0, '0, 5'd0);
		push_cmd(ACT_FIND_ID, 32'd77, '0, '0, 5'd0);
		push_cmd(ACT_FIND_NAME, '0, '0, "shell", 5'd0);
		push_cmd(ACT_FIND_NAME, '0, '0, '1, 5'd16);
		push_cmd(ACT_FIND_NAME, '0, '0, "SHELL", 5'd5);
		push_cmd(ACT_FIND_NAME, '0, '0, "SHELLxx", 5'd4);
		push_cmd(ACT_FIND_NAME, '0, '0, {8'h00, "she"}, 5'd4);
		push_cmd(ACT_FIND_NAME, '0, '0, "?z~ init.PROC9?", 5'd15);
		push_cmd(ACT_FIND_BASE, '0, '1, '0, 5'd0);
		push_cmd(ACT_FIND_BASE, '0, 64'd0, '0, 5'd0);
		push_cmd(ACT_FIND_BASE, '0, 64'd99, '0, 5'd0);
		push_cmd(ACT_TERMINATE, 32'd77, '0, '0, 5'd0);
		push_cmd(ACT_TERMINATE, 32'd5, '0, '0, 5'd0);
		push_cmd(ACT_FIND_BASE, '0, '1, '0, 5'd0);
		push_cmd(ACT_FIND_NAME, '0, '0, "shell", 5'd5);
		push_cmd(ACT_TERMINATE, 32'd0, '0, '0, 5'd0);
		push_cmd(ACT_TERMINATE, 32'hFFFF_FFFF, '0, '0, 5'd0);
		push_cmd(ACT_TERMINATE, 32'd6, '0, '0, 5'd0);

		// random: alternate growing and shrinking the table, ids from a small
		// range so duplicates, hits and a full table all occur
		for (int n = 0; n < RAND_CMDS; n++) begin
			idle_pct = (n < RAND_CMDS / 3) ? 38 : (n < 2 * RAND_CMDS / 3) ? 73 : 0;
			grow = ((n / 250) % 2) == 0;
			pick = $urandom_range(0, 99);
			idx = $urandom_range(0, used_pids.size() - 1);
			if (pick < (grow ? 70 : 15)) begin
				push_cmd(ACT_CREATE,
					($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(0, 299),
					random_base(), random_name(), 5'($urandom_range(0, 16)));
			end else if (pick < (grow ? 78 : 60)) begin
				push_cmd(ACT_TERMINATE, $urandom_range(0, 1) ? used_pids[idx] :
					$urandom_range(0, 299), random_base(), random_name(), 5'($urandom));
			end else if (pick < (grow ? 84 : 70)) begin
				push_cmd(ACT_FIND_ID, $urandom_range(0, 1) ? used_pids[idx] : $urandom,
					random_base(), random_name(), 5'($urandom));
			end else if (pick < (grow ? 94 : 88)) begin
				// lookup a handed-out name with random case flips
				nm = used_names[idx];
				len = used_lens[idx] > NCHARS ? 5'(NCHARS) : used_lens[idx];
				for (int k = 0; k < NCHARS; k++) begin
					if (lower(nm[8*k +: 8]) >= 8'h61 && lower(nm[8*k +: 8]) <= 8'h7A &&
							$urandom_range(0, 1)) begin
						nm[8*k +: 8] = nm[8*k +: 8] ^ 8'h20;
					end
				end
				if ($urandom_range(0, 9) == 0) len = 5'($urandom_range(0, 16));
				push_cmd(ACT_FIND_NAME, $urandom, random_base(), nm, len);
			end else begin
				push_cmd(ACT_FIND_BASE, $urandom,
					$urandom_range(0, 2) ? used_bases[idx] : random_base(),
					random_name(), 5'($urandom));
			end
		end

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		while (pending_q.size() > 0 || start || result_q.size() > 0) @(posedge clk);
		repeat (DRAIN) @(posedge clk);
		if (error_count == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

endmodule

@@ filelist.f @@
+incdir+rtl/core
rtl/core/pas_pkg.sv
rtl/core/pas_ram.sv
rtl/core/pas_match.sv
rtl/core/process_address_space_table_unit.sv
tb/sv/process_address_space_table_unit_tb.sv
